/* src/sstp_pkg.sv */
// Shared types, constants and helpers for the sparse triple product unit.
// No dependencies.
package sstp_pkg;

  localparam int SH_ORDER = 8;
  localparam int NCOEF    = SH_ORDER * SH_ORDER;
  localparam int SLOTS    = 64;
  localparam int IDX_W    = 6;
  localparam int COEF_W   = 16;
  localparam int ACC_W    = 48;
  localparam int PROD1_W  = 32;
  localparam int RND_SH   = 25;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_ENTRY  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic signed [COEF_W-1:0] tensor_weight;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [COEF_W-1:0] result_value;
    logic                     last;
  } out_word_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic take_entry;
    logic mul1;
    logic mul2;
    logic acc_wr;
    logic ro_start;
    logic ro_rd;
    logic ro_ld;
    logic ro_next;
    logic ro_clear;
  } ctl_t;

  typedef struct packed {
    logic ro_last;
  } sts_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] i);
    return {1'b0, i} < (IDX_W+1)'(NCOEF);
  endfunction

endpackage

/* src/sh_sparse_triple_product_unit.sv */
// Sparse spherical-harmonic triple product: top level.
// Depends on sstp_pkg, sstp_ctrl and sstp_datapath.
//
// Takes one input word at a time. A load of operand a or b is written to its store on acceptance.
// A tensor entry runs through store reads on acceptance, two registered multiplies (weight by a,
// then by b) and a saturating read-modify-write of the accumulator memory. A readout emits
// SH_ORDER*SH_ORDER words, each by a read of the single accumulator port, rounding into the
// output register and a handshake; after the full vector the accumulators read as zero again.
// Input is not taken while a readout is in progress. Stores and accumulators start at zero after
// reset with no clearing pass.
module sh_sparse_triple_product_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sstp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sstp_pkg::out_word_t out_data
);

  sstp_pkg::ctl_t ctl;
  sstp_pkg::sts_t sts;

  sstp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (in_data.command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  sstp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* src/sstp_datapath.sv */
// Datapath: operand stores, accumulator memory, multiplier chain, readout rounding.
// Depends on sstp_pkg.
module sstp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sstp_pkg::in_word_t  in_data,
  input  sstp_pkg::ctl_t      ctl,
  output sstp_pkg::sts_t      sts,
  output sstp_pkg::out_word_t out_data
);

  logic signed [sstp_pkg::COEF_W-1:0] a_mem [sstp_pkg::SLOTS];
  logic signed [sstp_pkg::COEF_W-1:0] b_mem [sstp_pkg::SLOTS];
  logic signed [sstp_pkg::ACC_W-1:0]  acc_mem [sstp_pkg::SLOTS];
  logic [sstp_pkg::SLOTS-1:0]         a_vld;
  logic [sstp_pkg::SLOTS-1:0]         b_vld;
  logic [sstp_pkg::SLOTS-1:0]         acc_vld;

  logic signed [sstp_pkg::COEF_W-1:0]  a_q, b_q, w_q;
  logic                                a_vq, b_vq, acc_vq, ent_ok;
  logic [sstp_pkg::IDX_W-1:0]          ic_q, k;
  logic signed [sstp_pkg::ACC_W-1:0]   acc_q;
  logic signed [sstp_pkg::PROD1_W-1:0] p1;
  logic signed [sstp_pkg::ACC_W-1:0]   p2;

  logic signed [sstp_pkg::COEF_W-1:0]  a_op, b_op;
  logic signed [sstp_pkg::PROD1_W-1:0] p1_next;
  logic signed [sstp_pkg::ACC_W-1:0]   p2_next, acc_op, acc_next;
  logic signed [sstp_pkg::ACC_W:0]     sum, rnd;
  logic signed [sstp_pkg::ACC_W-sstp_pkg::RND_SH:0] shr;
  logic signed [sstp_pkg::COEF_W-1:0]  rnd_val;
  logic [sstp_pkg::IDX_W-1:0]          acc_raddr;

  assign a_op    = a_vq ? a_q : '0;
  assign b_op    = b_vq ? b_q : '0;
  assign p1_next = w_q * a_op;
  assign p2_next = p1 * b_op;
  assign acc_op  = acc_vq ? acc_q : '0;
  assign sum     = {acc_op[sstp_pkg::ACC_W-1], acc_op} + {p2[sstp_pkg::ACC_W-1], p2};

  always_comb begin
    if (sum[sstp_pkg::ACC_W] != sum[sstp_pkg::ACC_W-1]) begin
      acc_next = sum[sstp_pkg::ACC_W] ? {1'b1, {(sstp_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(sstp_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum[sstp_pkg::ACC_W-1:0];
    end
  end

  assign rnd = {acc_op[sstp_pkg::ACC_W-1], acc_op}
             + ((sstp_pkg::ACC_W+1)'(1) << (sstp_pkg::RND_SH-1));
  assign shr = rnd[sstp_pkg::ACC_W:sstp_pkg::RND_SH];

  always_comb begin
    if (shr > $signed((sstp_pkg::ACC_W-sstp_pkg::RND_SH+1)'(32767))) begin
      rnd_val = 16'sh7FFF;
    end else if (shr < -$signed((sstp_pkg::ACC_W-sstp_pkg::RND_SH+1)'(32768))) begin
      rnd_val = 16'sh8000;
    end else begin
      rnd_val = shr[sstp_pkg::COEF_W-1:0];
    end
  end

  assign acc_raddr   = ctl.take_entry ? in_data.index_c : k;
  assign sts.ro_last = (k == sstp_pkg::IDX_W'(sstp_pkg::NCOEF-1));

  always_ff @(posedge clk) begin
    if (ctl.load_a && sstp_pkg::idx_ok(in_data.coeff_index)) begin
      a_mem[in_data.coeff_index] <= in_data.coeff_value;
    end
    if (ctl.load_b && sstp_pkg::idx_ok(in_data.coeff_index)) begin
      b_mem[in_data.coeff_index] <= in_data.coeff_value;
    end
    if (ctl.take_entry) begin
      a_q <= a_mem[in_data.index_a];
      b_q <= b_mem[in_data.index_b];
    end
    if (ctl.take_entry || ctl.ro_rd) begin
      acc_q <= acc_mem[acc_raddr];
    end
    if (ctl.acc_wr && ent_ok) begin
      acc_mem[ic_q] <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= '0;
      b_vld   <= '0;
      acc_vld <= '0;
    end else begin
      if (ctl.load_a && sstp_pkg::idx_ok(in_data.coeff_index)) begin
        a_vld[in_data.coeff_index] <= 1'b1;
      end
      if (ctl.load_b && sstp_pkg::idx_ok(in_data.coeff_index)) begin
        b_vld[in_data.coeff_index] <= 1'b1;
      end
      if (ctl.ro_clear) begin
        acc_vld <= '0;
      end else if (ctl.acc_wr && ent_ok) begin
        acc_vld[ic_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_entry) begin
      a_vq   <= a_vld[in_data.index_a];
      b_vq   <= b_vld[in_data.index_b];
      ic_q   <= in_data.index_c;
      w_q    <= in_data.tensor_weight;
      ent_ok <= sstp_pkg::idx_ok(in_data.index_a) && sstp_pkg::idx_ok(in_data.index_b)
                && sstp_pkg::idx_ok(in_data.index_c);
    end
    if (ctl.take_entry || ctl.ro_rd) begin
      acc_vq <= acc_vld[acc_raddr];
    end
    if (ctl.mul1) begin
      p1 <= p1_next;
    end
    if (ctl.mul2) begin
      p2 <= p2_next;
    end
    if (ctl.ro_start) begin
      k <= '0;
    end else if (ctl.ro_next) begin
      k <= k + 1'b1;
    end
    if (ctl.ro_ld) begin
      out_data.result_index <= k;
      out_data.result_value <= rnd_val;
      out_data.last         <= sts.ro_last;
    end
  end

endmodule

/* src/sstp_ctrl.sv */
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on sstp_pkg.
module sstp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       command,
  output logic             out_valid,
  input  logic             out_ready,
  output sstp_pkg::ctl_t   ctl,
  input  sstp_pkg::sts_t   sts
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL1    = 3'd1;
  localparam logic [2:0] S_MUL2    = 3'd2;
  localparam logic [2:0] S_ACC     = 3'd3;
  localparam logic [2:0] S_RO_RD   = 3'd4;
  localparam logic [2:0] S_RO_LD   = 3'd5;
  localparam logic [2:0] S_RO_WAIT = 3'd6;

  logic [2:0] state, state_next;
  logic       accept, out_take;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RO_WAIT);
  assign accept    = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  always_comb begin
    ctl            = '0;
    ctl.load_a     = accept && (command == sstp_pkg::CMD_LOAD_A);
    ctl.load_b     = accept && (command == sstp_pkg::CMD_LOAD_B);
    ctl.take_entry = accept && (command == sstp_pkg::CMD_ENTRY);
    ctl.ro_start   = accept && (command == sstp_pkg::CMD_READ);
    ctl.mul1       = (state == S_MUL1);
    ctl.mul2       = (state == S_MUL2);
    ctl.acc_wr     = (state == S_ACC);
    ctl.ro_rd      = (state == S_RO_RD);
    ctl.ro_ld      = (state == S_RO_LD);
    ctl.ro_next    = out_take && !sts.ro_last;
    ctl.ro_clear   = out_take && sts.ro_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.take_entry) begin
          state_next = S_MUL1;
        end else if (ctl.ro_start) begin
          state_next = S_RO_RD;
        end
      end
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = S_ACC;
      S_ACC:     state_next = S_IDLE;
      S_RO_RD:   state_next = S_RO_LD;
      S_RO_LD:   state_next = S_RO_WAIT;
      S_RO_WAIT: begin
        if (out_take) begin
          state_next = sts.ro_last ? S_IDLE : S_RO_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_entry_seq: assert property (@(posedge clk) disable iff (rst)
    ctl.take_entry |=> ##2 ctl.acc_wr)
    else $error("tensor entry did not reach accumulator write");

  a_acc_done: assert property (@(posedge clk) disable iff (rst)
    ctl.acc_wr |=> in_ready)
    else $error("not idle after accumulator write");

  a_ro_end: assert property (@(posedge clk) disable iff (rst)
    ctl.ro_clear |=> in_ready && !out_valid)
    else $error("readout did not end after last word");

endmodule
